@@ src/spt_pkg.sv @@
package spt_pkg;

  localparam int unsigned NUM_NOTES = 128;
  localparam int unsigned HALF_NOTES = NUM_NOTES / 2;

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_PEDAL    = 2'd2;

  // pedal positions at or above this mean down
  localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;

  typedef struct packed {
    logic                  send_note_on;
    logic                  send_note_off;
    logic [6:0]            out_note;
    logic [6:0]            out_velocity;
    logic [HALF_NOTES-1:0] release_low;
    logic [HALF_NOTES-1:0] release_high;
  } result_t;

endpackage

@@ src/spt_tracker.sv @@
module spt_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       operation,
  input  logic [6:0]       note,
  input  logic [6:0]       value,
  output spt_pkg::result_t result
);
  import spt_pkg::*;

  logic [NUM_NOTES-1:0] key_down_map;
  logic [NUM_NOTES-1:0] key_down_map_next;
  logic [NUM_NOTES-1:0] pedal_held_map;
  logic [NUM_NOTES-1:0] pedal_held_map_next;
  logic                 pedal_is_down;
  logic                 pedal_is_down_next;
  logic                 pedal_down;
  logic [NUM_NOTES-1:0] release_map;

  assign pedal_down  = (value >= PEDAL_THRESHOLD);
  assign release_map = pedal_held_map & ~key_down_map;

  always_comb begin
    result              = '0;
    key_down_map_next   = key_down_map;
    pedal_held_map_next = pedal_held_map;
    pedal_is_down_next  = pedal_is_down;
    unique case (operation)
      OP_NOTE_ON: begin
        key_down_map_next[note]   = 1'b1;
        pedal_held_map_next[note] = 1'b0;
        result.send_note_on       = 1'b1;
        result.out_note           = note;
        result.out_velocity       = value;
      end
      OP_NOTE_OFF: begin
        key_down_map_next[note] = 1'b0;
        if (pedal_is_down) begin
          // defer: the pedal keeps this note sounding
          pedal_held_map_next[note] = 1'b1;
        end else begin
          pedal_held_map_next[note] = 1'b0;
          result.send_note_off      = 1'b1;
          result.out_note           = note;
        end
      end
      OP_PEDAL: begin
        if (pedal_down != pedal_is_down) begin
          pedal_is_down_next = pedal_down;
          if (!pedal_down) begin
            // lift: release every held note whose key is up
            pedal_held_map_next = pedal_held_map & ~release_map;
            result.release_low  = release_map[HALF_NOTES-1:0];
            result.release_high = release_map[NUM_NOTES-1:HALF_NOTES];
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down_map   <= '0;
      pedal_held_map <= '0;
      pedal_is_down  <= 1'b0;
    end else if (accept) begin
      key_down_map   <= key_down_map_next;
      pedal_held_map <= pedal_held_map_next;
      pedal_is_down  <= pedal_is_down_next;
    end
  end

endmodule

@@ src/spt_out_buffer.sv @@
module spt_out_buffer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  spt_pkg::result_t load_word,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output spt_pkg::result_t out_word
);
  import spt_pkg::*;

  result_t skid_word;
  logic    skid_valid;
  logic    out_free;

  assign full     = skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      // output held: park the new word
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (load) begin
        out_word <= load_word;
      end
    end else if (load) begin
      skid_word <= load_word;
    end
  end

endmodule

@@ src/sustain_pedal_note_tracker.sv @@
// Sustain pedal note tracker: takes one MIDI note-on, note-off or pedal word
// per cycle unless stalled, and registers exactly one result word for each
// word it accepts. Key and pedal-hold maps are 128-bit registers updated in
// a single pass, so a pedal lift computes its full release mask in the same
// cycle. A two-word output stage (output register plus skid) lets input keep
// flowing while a result waits; in_stall rises only once both are held.
module sustain_pedal_note_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [6:0]  note,
  input  logic [6:0]  value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_note_on,
  output logic        send_note_off,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic [63:0] release_low,
  output logic [63:0] release_high
);
  import spt_pkg::*;

  logic    accept;
  logic    buffer_full;
  result_t result;
  result_t out_word;

  assign in_stall = buffer_full;
  assign accept   = in_valid && !buffer_full;

  spt_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .note      (note),
    .value     (value),
    .result    (result)
  );

  spt_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_word (result),
    .full      (buffer_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign send_note_on  = out_word.send_note_on;
  assign send_note_off = out_word.send_note_off;
  assign out_note      = out_word.out_note;
  assign out_velocity  = out_word.out_velocity;
  assign release_low   = out_word.release_low;
  assign release_high  = out_word.release_high;

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_OFF_AT = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam result_t NO_OUTPUT = '0;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] nt;
    logic [6:0] val;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [6:0]  note = '0;
  logic [6:0]  value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        send_note_on;
  logic        send_note_off;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic [63:0] release_low;
  logic [63:0] release_high;

  // tracker state as the block should hold it
  logic [127:0] keys_down = '0;
  logic [127:0] pedal_holds = '0;
  logic         pedal_down = 1'b0;

  result_t     expected_results[$];
  int unsigned words_in = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;

  bit          hold_off_done = 1'b0;
  bit          rx_stalling = 1'b0;
  int unsigned rx_left = 0;
  result_t     rx_want;

  // after reset, extremes, forwarded offs and silent cases are typed in
  stim_row_t directed_rows [0:24] = '{
    '{OP_NOTE_ON,  7'd0,   7'd127, 1'b1, '{1'b1, 1'b0, 7'd0,   7'd127, 64'd0, 64'd0}},
    '{OP_NOTE_ON,  7'd127, 7'd0,   1'b1, '{1'b1, 1'b0, 7'd127, 7'd0,   64'd0, 64'd0}},
    '{OP_NOTE_OFF, 7'd0,   7'd127, 1'b1, '{1'b0, 1'b1, 7'd0,   7'd0,   64'd0, 64'd0}},
    '{OP_NOTE_OFF, 7'd127, 7'd85,  1'b1, '{1'b0, 1'b1, 7'd127, 7'd0,   64'd0, 64'd0}},
    '{OP_NOTE_OFF, 7'd42,  7'd0,   1'b1, '{1'b0, 1'b1, 7'd42,  7'd0,   64'd0, 64'd0}},
    '{OP_PEDAL,    7'd127, 7'd63,  1'b1, NO_OUTPUT},
    '{OP_PEDAL,    7'd0,   7'd64,  1'b1, NO_OUTPUT},
    '{OP_PEDAL,    7'd55,  7'd127, 1'b1, NO_OUTPUT},
    '{OP_PEDAL,    7'd0,   7'd0,   1'b1, NO_OUTPUT},
    '{OP_PEDAL,    7'd0,   7'd100, 1'b1, NO_OUTPUT},
    '{OP_NOTE_OFF, 7'd127, 7'd0,   1'b1, NO_OUTPUT},
    '{OP_NOTE_OFF, 7'd0,   7'd0,   1'b1, NO_OUTPUT},
    '{OP_NOTE_ON,  7'd63,  7'd1,   1'b0, NO_OUTPUT},
    '{OP_NOTE_OFF, 7'd63,  7'd0,   1'b1, NO_OUTPUT},
    '{OP_NOTE_ON,  7'd64,  7'd127, 1'b0, NO_OUTPUT},
    '{OP_NOTE_OFF, 7'd64,  7'd0,   1'b1, NO_OUTPUT},
    '{OP_NOTE_ON,  7'd64,  7'd77,  1'b0, NO_OUTPUT},
    '{OP_NOTE_OFF, 7'd1,   7'd0,   1'b1, NO_OUTPUT},
    '{OP_NOTE_ON,  7'd1,   7'd50,  1'b0, NO_OUTPUT},
    '{OP_UNUSED,   7'd127, 7'd127, 1'b1, NO_OUTPUT},
    '{OP_PEDAL,    7'd0,   7'd63,  1'b0, NO_OUTPUT},
    '{OP_NOTE_OFF, 7'd64,  7'd0,   1'b0, NO_OUTPUT},
    '{OP_PEDAL,    7'd127, 7'd127, 1'b1, NO_OUTPUT},
    '{OP_NOTE_OFF, 7'd1,   7'd0,   1'b1, NO_OUTPUT},
    '{OP_PEDAL,    7'd0,   7'd0,   1'b0, NO_OUTPUT}
  };

  sustain_pedal_note_tracker i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .note          (note),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .send_note_on  (send_note_on),
    .send_note_off (send_note_off),
    .out_note      (out_note),
    .out_velocity  (out_velocity),
    .release_low   (release_low),
    .release_high  (release_high)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t track_event(input logic [1:0] op, input logic [6:0] nt,
                                          input logic [6:0] val);
    result_t      res;
    logic [127:0] freed;
    logic         down;
    res = '0;
    case (op)
      OP_NOTE_ON: begin
        keys_down[nt] = 1'b1;
        pedal_holds[nt] = 1'b0;
        res.send_note_on = 1'b1;
        res.out_note = nt;
        res.out_velocity = val;
      end
      OP_NOTE_OFF: begin
        keys_down[nt] = 1'b0;
        if (pedal_down) begin
          pedal_holds[nt] = 1'b1;
        end else begin
          pedal_holds[nt] = 1'b0;
          res.send_note_off = 1'b1;
          res.out_note = nt;
        end
      end
      OP_PEDAL: begin
        down = (val >= PEDAL_THRESHOLD);
        if (down != pedal_down) begin
          pedal_down = down;
          if (!down) begin
            // release held notes whose key is up
            freed = pedal_holds & ~keys_down;
            pedal_holds = pedal_holds & ~freed;
            res.release_low = freed[63:0];
            res.release_high = freed[127:64];
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [6:0] nt, input logic [6:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    note <= nt;
    value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(track_event(op, nt, val));
    words_in++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  initial begin
    int unsigned kind;
    int unsigned base;
    int unsigned roll;
    logic [6:0]  nt;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].nt, directed_rows[i].val);
      if (directed_rows[i].typed) expected_results[$] = directed_rows[i].want;
    end

    // hold every note with the pedal, then lift: both masks all ones
    idle_on = 1'b0;
    send_word(OP_PEDAL, 7'd0, 7'd127);
    for (int n = 0; n < 128; n++) send_word(OP_NOTE_OFF, 7'(n), 7'($urandom_range(0, 127)));
    send_word(OP_PEDAL, 7'd127, 7'd0);

    while (words_in < RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      idle_on = ($urandom_range(0, 3) != 0);
      if (kind < 7) begin
        // pedal session over a narrow window of keys, or the whole keyboard
        base = $urandom_range(0, 120);
        send_word(OP_PEDAL, 7'($urandom_range(0, 127)), 7'($urandom_range(64, 127)));
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(0, 3) == 0) nt = 7'($urandom_range(0, 127));
          else nt = 7'(base + $urandom_range(0, 7));
          roll = $urandom_range(0, 99);
          if (roll < 40) send_word(OP_NOTE_ON, nt, 7'($urandom_range(0, 127)));
          else if (roll < 95) send_word(OP_NOTE_OFF, nt, 7'($urandom_range(0, 127)));
          else send_word(OP_PEDAL, nt, 7'($urandom_range(64, 127)));
        end
        send_word(OP_PEDAL, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 63)));
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)));
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word, expected none got note %0d", $time, out_note);
      end else begin
        rx_want = expected_results.pop_front();
        check_field("send_note_on", 64'(rx_want.send_note_on), 64'(send_note_on));
        check_field("send_note_off", 64'(rx_want.send_note_off), 64'(send_note_off));
        check_field("out_note", 64'(rx_want.out_note), 64'(out_note));
        check_field("out_velocity", 64'(rx_want.out_velocity), 64'(out_velocity));
        check_field("release_low", rx_want.release_low, release_low);
        check_field("release_high", rx_want.release_high, release_high);
      end
    end

    // hold off once for long enough to fill the output stage
    if (!hold_off_done && words_in >= HOLD_OFF_AT) begin
      hold_off_done = 1'b1;
      rx_stalling = 1'b1;
      rx_left = HOLD_OFF_CYCLES;
    end else if (rx_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        rx_stalling = 1'b1;
        rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      end else begin
        rx_stalling = 1'b0;
        rx_left = $urandom_range(1, 40);
      end
    end else begin
      rx_left--;
    end
    out_stall <= rx_stalling;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
src/spt_pkg.sv
src/spt_tracker.sv
src/spt_out_buffer.sv
src/sustain_pedal_note_tracker.sv
tb/sv/tb.sv
